@@ sv/pva_pkg.sv @@
// Shared constants, types and helpers of the polyphonic voice allocator.
package pva_pkg;

  localparam int NUM_VOICES = 8;
  localparam int AGE_BITS   = 16;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);

  localparam int MODE_W = 3;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int FIN_W  = 3;
  localparam int ACT_W  = 3;
  localparam int OIDX_W = 3;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Input modes
  localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALL_OFF  = 3'd4;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RETRIG  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STEAL   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEARED = 3'd5;

  // Classified operations passed from front to back
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP  = 3'd0;
  localparam op_t OP_ON   = 3'd1;
  localparam op_t OP_OFF  = 3'd2;
  localparam op_t OP_FIN  = 3'd3;
  localparam op_t OP_TICK = 3'd4;
  localparam op_t OP_CLR  = 3'd5;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [VIDX_W-1:0] fin_idx;
  } cmd_t;

  // Low bits of a voice index as reported on the result channel
  function automatic logic [OIDX_W-1:0] idx_out(input logic [VIDX_W-1:0] v);
    logic [VIDX_W+OIDX_W-1:0] t;
    begin
      t = (VIDX_W + OIDX_W)'(v);
      return t[OIDX_W-1:0];
    end
  endfunction

endpackage

@@ sv/pva_if.sv @@
// Channel interfaces: input event and result transactions.
interface pva_in_if;
  logic                      valid;
  logic                      ready;
  logic [pva_pkg::MODE_W-1:0] mode;
  logic [pva_pkg::NOTE_W-1:0] note;
  logic [pva_pkg::VEL_W-1:0]  velocity;
  logic [pva_pkg::FIN_W-1:0]  finished_voice;

  modport source (output valid, mode, note, velocity, finished_voice, input ready);
  modport sink   (input valid, mode, note, velocity, finished_voice, output ready);
endinterface

interface pva_out_if;
  logic                       valid;
  logic                       ready;
  logic [pva_pkg::ACT_W-1:0]  action;
  logic [pva_pkg::OIDX_W-1:0] voice_index;
  logic [pva_pkg::NOTE_W-1:0] note_out;
  logic [pva_pkg::VEL_W-1:0]  velocity_out;
  logic [pva_pkg::NOTE_W-1:0] stolen_note;

  modport source (output valid, action, voice_index, note_out, velocity_out, stolen_note,
                  input ready);
  modport sink   (input valid, action, voice_index, note_out, velocity_out, stolen_note,
                  output ready);
endinterface

@@ sv/pva_front.sv @@
// Front end: accepts event transactions, classifies them and queues commands.
module pva_front (
  input  logic           clk,
  input  logic           rst_n,
  pva_in_if.sink         in_ch,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output pva_pkg::cmd_t  cmd
);
  import pva_pkg::*;

  cmd_t        q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  cmd_t        cls;
  logic [31:0] fin_wide;
  logic        push;
  logic        pop;

  assign fin_wide = 32'(in_ch.finished_voice);

  always_comb begin
    cls          = '0;
    cls.note     = in_ch.note;
    cls.velocity = in_ch.velocity;
    cls.fin_idx  = fin_wide[VIDX_W-1:0];
    case (in_ch.mode)
      MODE_NOTE_ON:  cls.op = (in_ch.velocity != '0) ? OP_ON : OP_OFF;
      MODE_NOTE_OFF: cls.op = OP_OFF;
      // drop a finished index beyond the table
      MODE_FINISHED: cls.op = (fin_wide < 32'(NUM_VOICES)) ? OP_FIN : OP_NOP;
      MODE_TICK:     cls.op = OP_TICK;
      MODE_ALL_OFF:  cls.op = OP_CLR;
      default:       cls.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ sv/pva_back.sv @@
// Back end: voice table, sequential voice scan and result register.
module pva_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pva_pkg::cmd_t  cmd,
  pva_out_if.source      out_ch
);
  import pva_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]            st_r, st_nxt;
  cmd_t                  cmd_r;
  logic [NUM_VOICES-1:0] act_r;
  logic [NUM_VOICES-1:0] rel_r;

  // note and age store, one read and one write port
  logic [NOTE_W-1:0]     note_mem [NUM_VOICES];
  logic [AGE_BITS-1:0]   age_mem  [NUM_VOICES];
  logic [NOTE_W-1:0]     rd_note_r;
  logic [AGE_BITS-1:0]   rd_age_r;
  logic [VIDX_W-1:0]     rd_a;
  logic                  mem_we;
  logic [VIDX_W-1:0]     mem_wa;
  logic [NOTE_W-1:0]     mem_wn;
  logic [AGE_BITS-1:0]   mem_wage;

  logic [CNT_W-1:0]      cnt_r;
  logic                  p_vld_r;
  logic [VIDX_W-1:0]     p_idx_r;
  logic                  issue;

  logic                  match_f_r, free_f_r, rel_f_r, old_f_r;
  logic [VIDX_W-1:0]     match_i_r, free_i_r, rel_i_r, old_i_r;
  logic [AGE_BITS-1:0]   rel_age_r, old_age_r;
  logic [NOTE_W-1:0]     rel_note_r, old_note_r;
  logic                  p_act, p_rel;

  logic                  take;
  logic                  apply_go;
  logic [VIDX_W-1:0]     sel_v;
  logic [ACT_W-1:0]      sel_act;
  logic [NOTE_W-1:0]     sel_stolen;

  logic                  out_valid_r;
  logic [ACT_W-1:0]      out_act_r;
  logic [OIDX_W-1:0]     out_idx_r;
  logic [NOTE_W-1:0]     out_note_r;
  logic [VEL_W-1:0]      out_vel_r;
  logic [NOTE_W-1:0]     out_stolen_r;

  assign cmd_ready = (st_r == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign apply_go  = (st_r == ST_APPLY) && (!out_valid_r || out_ch.ready);
  assign issue     = (st_r == ST_SCAN) && (cnt_r != CNT_W'(NUM_VOICES));
  assign rd_a      = cnt_r[VIDX_W-1:0];
  assign p_act     = act_r[p_idx_r];
  assign p_rel     = rel_r[p_idx_r];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          if (cmd.op == OP_ON || cmd.op == OP_OFF || cmd.op == OP_TICK) begin
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        if (!issue && !p_vld_r) begin
          st_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Victim choice: matching note, then free voice, then oldest releasing, then oldest
  always_comb begin
    if (match_f_r) begin
      sel_v   = match_i_r;
      sel_act = ACT_RETRIG;
    end else if (free_f_r) begin
      sel_v   = free_i_r;
      sel_act = ACT_START;
    end else if (rel_f_r) begin
      sel_v   = rel_i_r;
      sel_act = ACT_STEAL;
    end else begin
      sel_v   = old_i_r;
      sel_act = ACT_STEAL;
    end
    sel_stolen = rel_f_r ? rel_note_r : old_note_r;
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = p_idx_r;
    mem_wn   = rd_note_r;
    mem_wage = rd_age_r + AGE_BITS'(1);
    if (st_r == ST_SCAN && p_vld_r && cmd_r.op == OP_TICK && p_act && rd_age_r != AGE_MAX) begin
      mem_we = 1'b1;
    end else if (apply_go && cmd_r.op == OP_ON) begin
      mem_we   = 1'b1;
      mem_wa   = sel_v;
      mem_wn   = cmd_r.note;
      mem_wage = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[mem_wa] <= mem_wn;
      age_mem[mem_wa]  <= mem_wage;
    end
    rd_note_r <= note_mem[rd_a];
    rd_age_r  <= age_mem[rd_a];
  end

  // Scan accumulators and command hold
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r     <= cmd;
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      rel_f_r   <= 1'b0;
      old_f_r   <= 1'b0;
    end else if (st_r == ST_SCAN && p_vld_r) begin
      if (!match_f_r && p_act && rd_note_r == cmd_r.note) begin
        match_f_r <= 1'b1;
        match_i_r <= p_idx_r;
      end
      if (!free_f_r && !p_act) begin
        free_f_r <= 1'b1;
        free_i_r <= p_idx_r;
      end
      if (p_act && p_rel && (!rel_f_r || rd_age_r > rel_age_r)) begin
        rel_f_r    <= 1'b1;
        rel_i_r    <= p_idx_r;
        rel_age_r  <= rd_age_r;
        rel_note_r <= rd_note_r;
      end
      if (!old_f_r || rd_age_r > old_age_r) begin
        old_f_r    <= 1'b1;
        old_i_r    <= p_idx_r;
        old_age_r  <= rd_age_r;
        old_note_r <= rd_note_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      p_idx_r     <= '0;
      act_r       <= '0;
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      p_vld_r <= issue;
      p_idx_r <= rd_a;
      if (take) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (apply_go) begin
        out_valid_r <= 1'b1;
        case (cmd_r.op)
          OP_ON: begin
            act_r[sel_v] <= 1'b1;
            rel_r[sel_v] <= 1'b0;
          end
          OP_OFF: begin
            if (match_f_r) begin
              rel_r[match_i_r] <= 1'b1;
            end
          end
          OP_FIN: begin
            act_r[cmd_r.fin_idx] <= 1'b0;
            rel_r[cmd_r.fin_idx] <= 1'b0;
          end
          OP_CLR: begin
            act_r <= '0;
            rel_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_act_r    <= ACT_NONE;
      out_idx_r    <= '0;
      out_note_r   <= '0;
      out_vel_r    <= '0;
      out_stolen_r <= '0;
      case (cmd_r.op)
        OP_ON: begin
          out_act_r  <= sel_act;
          out_idx_r  <= idx_out(sel_v);
          out_note_r <= cmd_r.note;
          out_vel_r  <= cmd_r.velocity;
          if (sel_act == ACT_STEAL) begin
            out_stolen_r <= sel_stolen;
          end
        end
        OP_OFF: begin
          if (match_f_r) begin
            out_act_r  <= ACT_RELEASE;
            out_idx_r  <= idx_out(match_i_r);
            out_note_r <= cmd_r.note;
          end
        end
        OP_CLR:  out_act_r <= ACT_CLEARED;
        default: out_act_r <= ACT_NONE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_act_r;
  assign out_ch.voice_index  = out_idx_r;
  assign out_ch.note_out     = out_note_r;
  assign out_ch.velocity_out = out_vel_r;
  assign out_ch.stolen_note  = out_stolen_r;

endmodule

@@ sv/poly_voice_allocator.sv @@
// Top level of the polyphonic voice allocator with oldest-voice stealing that prefers releasing voices.
//
//  Channel  Dir  Handshake      Payload
//  in_ch    in   valid/ready    mode, note, velocity, finished_voice
//  out_ch   out  valid/ready    action, voice_index, note_out, velocity_out, stolen_note
//
// Note on, note off and block tick walk the voice table one voice per cycle through
// the single read port of the note/age store, then apply the result. Voice finished,
// all-off and unused modes skip the scan and go straight to the apply state.
// A two-entry command queue sits between the front and the back end, so events are
// taken while the back end scans or while a result waits in the output register.
// Synchronous active-low reset clears the voice table flags and all handshake state.
module poly_voice_allocator (
  input logic        clk,
  input logic        rst_n,
  pva_in_if.sink     in_ch,
  pva_out_if.source  out_ch
);
  import pva_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  pva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pva_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/poly_voice_allocator_checker.sv @@
// Scoreboard for the voice allocator: predicts each result transaction and compares it.
`timescale 1ns / 100ps

module poly_voice_allocator_checker (
  input  logic clk,
  input  logic rst_n,
  pva_in_if    in_ch,
  pva_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import pva_pkg::*;

  localparam int NO_VOICE = -1;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OIDX_W-1:0] voice_index;
    logic [NOTE_W-1:0] note_out;
    logic [VEL_W-1:0]  velocity_out;
    logic [NOTE_W-1:0] stolen_note;
  } voice_result_t;

  logic                voice_busy   [NUM_VOICES];
  logic                voice_fading [NUM_VOICES];
  logic [NOTE_W-1:0]   voice_pitch  [NUM_VOICES];
  logic [AGE_BITS-1:0] voice_ticks  [NUM_VOICES];

  voice_result_t allocations_due[$];
  int            errors = 0;

  function automatic void clear_table();
    for (int v = 0; v < NUM_VOICES; v++) begin
      voice_busy[v]   = 1'b0;
      voice_fading[v] = 1'b0;
      voice_pitch[v]  = '0;
      voice_ticks[v]  = '0;
    end
  endfunction

  function automatic int voice_holding(input logic [NOTE_W-1:0] pitch);
    for (int v = 0; v < NUM_VOICES; v++)
      if (voice_busy[v] && voice_pitch[v] == pitch) return v;
    return NO_VOICE;
  endfunction

  // Oldest fading voice first, else oldest of all; strict compare keeps the lowest index on ties
  function automatic int oldest_voice();
    int                  best;
    logic [AGE_BITS-1:0] best_age;
    best     = NO_VOICE;
    best_age = '0;
    for (int v = 0; v < NUM_VOICES; v++)
      if (voice_busy[v] && voice_fading[v] && (best == NO_VOICE || voice_ticks[v] > best_age)) begin
        best     = v;
        best_age = voice_ticks[v];
      end
    if (best != NO_VOICE) return best;
    for (int v = 0; v < NUM_VOICES; v++)
      if (best == NO_VOICE || voice_ticks[v] > best_age) begin
        best     = v;
        best_age = voice_ticks[v];
      end
    return best;
  endfunction

  function automatic voice_result_t predict_allocation(input logic [MODE_W-1:0] mode_in,
                                                       input logic [NOTE_W-1:0] pitch,
                                                       input logic [VEL_W-1:0]  vel,
                                                       input logic [FIN_W-1:0]  fin);
    voice_result_t    r;
    logic [MODE_W-1:0] mode;
    int               v;
    r    = '0;
    mode = mode_in;
    // zero velocity note on behaves as note off
    if (mode == MODE_NOTE_ON && vel == '0) mode = MODE_NOTE_OFF;
    case (mode)
      MODE_NOTE_ON: begin
        v = voice_holding(pitch);
        if (v != NO_VOICE) begin
          r.action = ACT_RETRIG;
        end else begin
          for (int i = NUM_VOICES - 1; i >= 0; i--)
            if (!voice_busy[i]) v = i;
          if (v != NO_VOICE) begin
            r.action = ACT_START;
          end else begin
            v             = oldest_voice();
            r.action      = ACT_STEAL;
            r.stolen_note = voice_pitch[v];
          end
        end
        voice_busy[v]   = 1'b1;
        voice_fading[v] = 1'b0;
        voice_pitch[v]  = pitch;
        voice_ticks[v]  = '0;
        r.voice_index   = OIDX_W'(v);
        r.note_out      = pitch;
        r.velocity_out  = vel;
      end
      MODE_NOTE_OFF: begin
        v = voice_holding(pitch);
        if (v != NO_VOICE) begin
          voice_fading[v] = 1'b1;
          r.action        = ACT_RELEASE;
          r.voice_index   = OIDX_W'(v);
          r.note_out      = pitch;
        end
      end
      MODE_FINISHED: begin
        if (int'(fin) < NUM_VOICES) begin
          voice_busy[fin]   = 1'b0;
          voice_fading[fin] = 1'b0;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < NUM_VOICES; i++)
          if (voice_busy[i] && voice_ticks[i] != AGE_MAX) voice_ticks[i] = voice_ticks[i] + 1'b1;
      end
      MODE_ALL_OFF: begin
        clear_table();
        r.action = ACT_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string field, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
  endtask

  always @(posedge clk) begin : scoreboard
    voice_result_t want;
    if (!rst_n) begin
      clear_table();
      allocations_due.delete();
    end else begin
      // results first: an output transaction always belongs to an earlier input
      if (out_ch.valid && out_ch.ready) begin
        if (allocations_due.size() == 0) begin
          report_mismatch($sformatf("result transaction with nothing outstanding, action %0d",
                                    out_ch.action));
        end else begin
          want = allocations_due.pop_front();
          compare_field("action", 8'(out_ch.action), 8'(want.action));
          compare_field("voice_index", 8'(out_ch.voice_index), 8'(want.voice_index));
          compare_field("note_out", 8'(out_ch.note_out), 8'(want.note_out));
          compare_field("velocity_out", 8'(out_ch.velocity_out), 8'(want.velocity_out));
          compare_field("stolen_note", 8'(out_ch.stolen_note), 8'(want.stolen_note));
        end
      end
      if (in_ch.valid && in_ch.ready)
        allocations_due.push_back(predict_allocation(in_ch.mode, in_ch.note, in_ch.velocity,
                                                     in_ch.finished_voice));
    end
    pending    <= allocations_due.size();
    fail_count <= errors;
  end

endmodule

@@ tb/poly_voice_allocator_tb.sv @@
// Testbench top for the voice allocator: clock, reset, event stimulus, receiver and verdict.
`timescale 1ns / 100ps

module poly_voice_allocator_tb;
  import pva_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int RANDOM_EVENTS   = 980;
  localparam int AGE_TICKS       = 8;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_ALL_OFF + 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   stall_requests = 0;
  int   idle_cycles    = 0;
  bit   steady         = 1'b0;
  int   burst_left     = 0;
  logic [NOTE_W-1:0] pool_base = 7'd48;

  pva_in_if  in_ch ();
  pva_out_if out_ch ();

  poly_voice_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poly_voice_allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one event and hold it until the transaction completes
  task automatic put_event(input logic [MODE_W-1:0] mode, input logic [NOTE_W-1:0] pitch,
                           input logic [VEL_W-1:0] vel, input logic [FIN_W-1:0] fin);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.note           <= pitch;
    in_ch.velocity       <= vel;
    in_ch.finished_voice <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly musical traffic on a small note pool, with some raw noise
  task automatic put_random_event();
    int                pick;
    logic [NOTE_W-1:0] pitch;
    logic [VEL_W-1:0]  vel;
    logic [FIN_W-1:0]  fin;
    pick  = $urandom_range(0, 99);
    pitch = ($urandom_range(0, 9) == 0) ? NOTE_W'($urandom) :
                                          pool_base + NOTE_W'($urandom_range(0, 11));
    vel   = ($urandom_range(0, 19) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
    fin   = FIN_W'($urandom);
    if (pick < 40)
      put_event(MODE_NOTE_ON, pitch, vel, fin);
    else if (pick < 60)
      put_event(MODE_NOTE_OFF, pitch, VEL_W'($urandom), fin);
    else if (pick < 72)
      put_event(MODE_FINISHED, NOTE_W'($urandom), VEL_W'($urandom), fin);
    else if (pick < 92)
      put_event(MODE_TICK, NOTE_W'($urandom), VEL_W'($urandom), fin);
    else if (pick < 94)
      put_event(MODE_ALL_OFF, NOTE_W'($urandom), VEL_W'($urandom), fin);
    else if (pick < 97)
      put_event(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), pitch, vel, fin);
    else
      put_event(MODE_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom), fin);
  endtask

  initial begin : stimulus
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= MODE_NOTE_ON;
    in_ch.note           <= '0;
    in_ch.velocity       <= '0;
    in_ch.finished_voice <= '0;
    rst_n                <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every mode and the corner cases
    put_event(MODE_NOTE_ON, 7'd0, 7'd127, 3'd0);
    put_event(MODE_NOTE_ON, 7'd127, 7'd1, 3'd0);
    put_event(MODE_NOTE_ON, 7'd0, 7'd5, 3'd0);      // retrigger
    put_event(MODE_NOTE_ON, 7'd60, 7'd0, 3'd0);     // zero velocity, nothing held
    put_event(MODE_NOTE_ON, 7'd127, 7'd0, 3'd0);    // zero velocity releases
    put_event(MODE_NOTE_OFF, 7'd127, 7'd0, 3'd0);   // already fading
    put_event(MODE_NOTE_OFF, 7'd99, 7'd127, 3'd7);  // no match
    put_event(MODE_TICK, 7'd127, 7'd127, 3'd7);
    put_event(MODE_FINISHED, 7'd0, 7'd0, 3'd7);     // idle voice
    put_event(MODE_FINISHED, 7'd0, 7'd0, 3'd1);
    for (int i = 0; i < 7; i++)
      put_event(MODE_NOTE_ON, NOTE_W'(10 + i), VEL_W'(20 + 15 * i), 3'd0);
    put_event(MODE_TICK, 7'd0, 7'd0, 3'd0);
    put_event(MODE_NOTE_ON, 7'd20, 7'd90, 3'd0);    // steal, nothing fading
    put_event(MODE_NOTE_OFF, 7'd11, 7'd0, 3'd0);
    put_event(MODE_NOTE_ON, 7'd21, 7'd91, 3'd0);    // steal the fading voice
    put_event(MODE_SPARE_FIRST, 7'd127, 7'd127, 3'd7);
    put_event(MODE_SPARE_FIRST + 3'd1, 7'd85, 7'd42, 3'd5);
    put_event(MODE_SPARE_LAST, 7'd42, 7'd85, 3'd2);
    put_event(MODE_ALL_OFF, 7'd127, 7'd127, 3'd7);

    // hold the receiver off until the block backs up, then drain
    stall_requests <= stall_requests + 1;
    repeat (24) put_random_event();
    wait_drained();

    // age the older voices together so that the steal falls back to the lowest index
    steady = 1'b1;
    put_event(MODE_ALL_OFF, 7'd0, 7'd0, 3'd0);
    for (int i = 0; i < NUM_VOICES; i++)
      put_event(MODE_NOTE_ON, NOTE_W'(30 + i), VEL_W'(64 + i), 3'd0);
    put_event(MODE_TICK, 7'd0, 7'd0, 3'd0);
    put_event(MODE_FINISHED, 7'd0, 7'd0, 3'd0);
    put_event(MODE_NOTE_ON, 7'd40, 7'd100, 3'd0);
    repeat (AGE_TICKS) put_event(MODE_TICK, 7'd0, 7'd0, 3'd0);
    put_event(MODE_NOTE_ON, 7'd41, 7'd101, 3'd0);
    put_event(MODE_NOTE_ON, 7'd42, 7'd102, 3'd0);
    wait_drained();
    steady = 1'b0;

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 100 == 0) pool_base = NOTE_W'($urandom_range(0, 116));
      if (n == RANDOM_EVENTS / 2) stall_requests <= stall_requests + 1;
      if (n == (RANDOM_EVENTS * 2) / 3) wait_drained();
      put_random_event();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Receiver: rotating ready masks per segment, plus long hold-offs on request
  initial begin : result_taker
    int          seg_left;
    int          phase;
    int          hold_left;
    int          stalls_done;
    logic [15:0] mask;
    seg_left    = 0;
    phase       = 0;
    hold_left   = 0;
    stalls_done = 0;
    mask        = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stalls_done != stall_requests) begin
        stalls_done++;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 96);
          case ($urandom_range(0, 2))
            0:       mask = '1;
            1:       mask = 16'($urandom);
            default: mask = 16'($urandom) | 16'($urandom);
          endcase
          if (mask == '0) mask = 16'h8001;
        end
        out_ch.ready <= mask[phase];
        phase = (phase + 1) % 16;
        seg_left--;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
